@@ hdl/spt_pkg.sv @@
`default_nettype none
package spt_pkg;

  localparam int unsigned PwW      = 16;  // pulse width
  localparam int unsigned ThrW     = 11;  // throttle
  localparam int unsigned CodeW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned NumW     = 28;  // map numerator
  localparam int unsigned DenW     = 17;  // map denominator
  localparam int unsigned QuoW     = 11;  // map quotient, always below 2048
  localparam int unsigned DivCntW  = 4;

  localparam logic [DivCntW-1:0] DivLast = DivCntW'(QuoW - 1);

  // register indexes
  localparam logic [CfgIdxW-1:0] RegBidir    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegNeutral  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMaxStep  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLowInit  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegHighInit = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCalStart = 3'd5;

  // register reset values
  localparam logic        RstBidir    = 1'b0;
  localparam logic [11:0] RstNeutral  = 12'd1500;
  localparam logic [10:0] RstMaxStep  = 11'd250;
  localparam logic [10:0] RstLowInit  = 11'd1000;
  localparam logic [11:0] RstHighInit = 12'd2000;
  localparam logic        RstCalStart = 1'b0;

  // controller to datapath
  typedef struct packed {
    logic                 load;     // latch request pulse width
    logic                 setup;    // select map range, multiply
    logic                 div_step; // one quotient bit
    logic [DivCntW-1:0]   div_bit;
    logic                 commit;   // update state, load result
  } spt_cmd_t;

endpackage
`default_nettype wire

@@ hdl/spt_ctrl.sv @@
`default_nettype none
module spt_ctrl
  import spt_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output spt_cmd_t  cmd_o
);

  typedef enum logic [1:0] {S_IDLE, S_SETUP, S_DIV, S_DONE} state_e;

  state_e             state_q;
  logic [DivCntW-1:0] cnt_q;
  logic               out_valid_q;
  logic               out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.setup    = (state_q == S_SETUP);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.div_bit  = DivLast - cnt_q;
    cmd_o.commit   = (state_q == S_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_SETUP;
        end
        S_SETUP: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DivLast) state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/spt_dp.sv @@
`default_nettype none
module spt_dp
  import spt_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire spt_cmd_t            cmd_i,
  input  wire logic [PwW-1:0]      pulse_width_i,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output logic [ThrW-1:0]          throttle_o,
  output logic [ThrW-1:0]          raw_value_o,
  output logic                     pulse_in_range_o,
  output logic                     calibrating_o,
  output logic                     high_captured_o,
  output logic                     calibration_saved_o,
  output logic [CodeW-1:0]         high_code_o,
  output logic [CodeW-1:0]         low_code_o
);

  // configuration
  logic        bidir_q;
  logic [11:0] neutral_q;
  logic [10:0] max_step_q;

  // block state
  logic        ca_q, hd_q;
  logic [7:0]  hc_q, lc_q;
  logic [15:0] lh_q, le_q, he_q;
  logic [10:0] held_q, sm_q;

  // per-request work registers
  logic [PwW-1:0]  w_q;
  logic [NumW-1:0] rem_q;
  logic [DenW-1:0] den_q;
  logic [QuoW-1:0] quo_q;
  logic [10:0]     base_q;
  logic            degen_q, unidir_q;

  // ---- map setup: range select, clamp, multiply ----
  logic signed [17:0] xs, los, his, dens, xc;
  logic [10:0]        span, base;
  logic               lowside, unidir, degen;
  logic [DenW-1:0]    diff;

  always_comb begin
    xs      = $signed({2'b00, w_q});
    lowside = bidir_q && ({4'd0, neutral_q} >= w_q);
    unidir  = !bidir_q;
    if (!bidir_q) begin
      los = $signed({{2{le_q[15]}}, le_q});
      his = $signed({{2{he_q[15]}}, he_q});
      base = 11'd47;  span = 11'd2000;
    end else if (lowside) begin
      los = $signed({{2{le_q[15]}}, le_q});
      his = $signed({6'd0, neutral_q});
      base = 11'd0;   span = 11'd1000;
    end else begin
      los = $signed({6'd0, neutral_q}) + 18'sd1;
      his = $signed({{2{he_q[15]}}, he_q});
      base = 11'd1001; span = 11'd999;
    end
    dens  = his - los;
    degen = (dens <= 18'sd0);
    if (xs < los)      xc = los;
    else if (xs > his) xc = his;
    else               xc = xs;
    diff = degen ? '0 : DenW'(xc - los);
  end

  // ---- restoring divide, one quotient bit per cycle ----
  logic [NumW-1:0] trial;
  assign trial = NumW'({{(NumW-DenW){1'b0}}, den_q} << cmd_i.div_bit);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) w_q <= pulse_width_i;
    if (cmd_i.setup) begin
      rem_q    <= NumW'(diff) * NumW'(span);
      den_q    <= degen ? DenW'(1) : DenW'(dens);
      quo_q    <= '0;
      base_q   <= base;
      degen_q  <= degen;
      unidir_q <= unidir;
    end else if (cmd_i.div_step) begin
      if (rem_q >= trial) begin
        rem_q               <= rem_q - trial;
        quo_q[cmd_i.div_bit] <= 1'b1;
      end
    end
  end

  // ---- result and state update ----
  logic               ok;
  logic [11:0]        raw_full;
  logic [10:0]        raw_map;
  logic               ca, hd, cap, sav;
  logic [7:0]         hc, lc;
  logic [15:0]        lh, le, he;
  logic [10:0]        hraw, sm;
  logic signed [19:0] h20, l20, dd, w20;
  logic signed [12:0] up, dn, stp;
  logic signed [16:0] hcd, lcd, hq, lq;

  always_comb begin
    ok       = (w_q > 16'd800) && (w_q < 16'd2200);
    raw_full = degen_q ? {1'b0, base_q} : ({1'b0, quo_q} + {1'b0, base_q});
    if (unidir_q && raw_full <= 12'd48) raw_full = '0;
    raw_map  = raw_full[10:0];
    w20      = $signed({4'd0, w_q});

    ca = ca_q; hd = hd_q; hc = hc_q; lc = lc_q; lh = lh_q; le = le_q; he = he_q;
    cap = 1'b0; sav = 1'b0; hraw = held_q;
    h20 = '0; l20 = '0; dd = '0;
    if (ok) begin
      if (ca_q) begin
        if (!hd) begin
          h20 = $signed({{4{he[15]}}, he});
          if (hc == 8'd0) lh = w_q;
          hc = hc + 8'd1;
          dd = $signed({{4{lh[15]}}, lh}) - h20;
          if (dd < 20'sd0) dd = -dd;
          if (dd > 20'sd50) begin
            ca = 1'b0;
          end else begin
            h20 = (h20 * 20'sd7 + w20) >>> 3;
            if (hc > 8'd50) begin
              h20 = h20 - 20'sd25;
              hd  = 1'b1;
              cap = 1'b1;
            end
            he = h20[15:0];
          end
          lh = he;
        end
        if (hd) begin
          if (w_q < 16'd1250) begin
            lc  = lc + 8'd1;
            l20 = ($signed({{4{le[15]}}, le}) * 20'sd7 + w20) >>> 3;
            le  = l20[15:0];
          end
          if (lc > 8'd75) begin
            le  = le + 16'd25;
            ca  = 1'b0;
            lc  = 8'd0;
            sav = 1'b1;
          end
        end
      end else begin
        hraw = raw_map;
      end
    end

    // slew limit
    up  = $signed({2'b00, hraw}) - $signed({2'b00, sm_q});
    dn  = -up;
    stp = $signed({2'b00, max_step_q});
    if (up > stp)      sm = sm_q + max_step_q;
    else if (dn > stp) sm = sm_q - max_step_q;
    else               sm = hraw;

    // codes, division by two truncating toward zero
    hcd = $signed({he[15], he}) - 17'sd1750;
    lcd = $signed({le[15], le}) - 17'sd750;
    hq  = (hcd + {16'd0, hcd[16]}) >>> 1;
    lq  = (lcd + {16'd0, lcd[16]}) >>> 1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      throttle_o          <= sm;
      raw_value_o         <= hraw;
      pulse_in_range_o    <= ok;
      calibrating_o       <= ca;
      high_captured_o     <= cap;
      calibration_saved_o <= sav;
      high_code_o         <= hq[7:0];
      low_code_o          <= lq[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bidir_q     <= RstBidir;
      neutral_q   <= RstNeutral;
      max_step_q  <= RstMaxStep;
      ca_q   <= RstCalStart;
      hd_q   <= 1'b0;
      hc_q   <= '0;
      lc_q   <= '0;
      lh_q   <= '0;
      le_q   <= {5'd0, RstLowInit};
      he_q   <= {4'd0, RstHighInit};
      held_q <= '0;
      sm_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegBidir:    bidir_q    <= cfg_data_i[0];
        RegNeutral:  neutral_q  <= cfg_data_i;
        RegMaxStep:  max_step_q <= cfg_data_i[10:0];
        RegLowInit: begin
          le_q <= {5'd0, cfg_data_i[10:0]};
        end
        RegHighInit: begin
          he_q <= {4'd0, cfg_data_i};
        end
        RegCalStart: begin
          ca_q        <= cfg_data_i[0];
          hd_q        <= 1'b0;
          hc_q        <= '0;
          lc_q        <= '0;
          lh_q        <= '0;
        end
        default: ;
      endcase
    end else if (cmd_i.commit) begin
      ca_q   <= ca;
      hd_q   <= hd;
      hc_q   <= hc;
      lc_q   <= lc;
      lh_q   <= lh;
      le_q   <= le;
      he_q   <= he;
      held_q <= hraw;
      sm_q   <= sm;
    end
  end

endmodule
`default_nettype wire

@@ hdl/servo_pulse_throttle_decoder.sv @@
// Each accepted request goes through setup/multiply, the divide iterations of
// the restoring map divider (one per quotient bit), then commit.
// Requests stall until the previous one has committed, held by the serial map
// divider; a new request is taken while the previous result still waits
// downstream.
// Reset (async, active low) loads register defaults, endpoints and clears state.
`default_nettype none
module servo_pulse_throttle_decoder
  import spt_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // request channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [PwW-1:0]      in_pulse_width_i,
  // result channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [ThrW-1:0]          out_throttle_o,
  output logic [ThrW-1:0]          out_raw_value_o,
  output logic                     out_pulse_in_range_o,
  output logic                     out_calibrating_o,
  output logic                     out_high_captured_o,
  output logic                     out_calibration_saved_o,
  output logic [CodeW-1:0]         out_high_code_o,
  output logic [CodeW-1:0]         out_low_code_o,
  // register write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  spt_cmd_t cmd;

  // writes are registered and always taken
  assign cfg_ready_o = 1'b1;

  // controller: sequences setup, divide iterations and commit
  spt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // datapath: map, divider, calibration filters, slew limiter, result regs
  spt_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .pulse_width_i       (in_pulse_width_i),
    .cfg_we_i            (cfg_valid_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .throttle_o          (out_throttle_o),
    .raw_value_o         (out_raw_value_o),
    .pulse_in_range_o    (out_pulse_in_range_o),
    .calibrating_o       (out_calibrating_o),
    .high_captured_o     (out_high_captured_o),
    .calibration_saved_o (out_calibration_saved_o),
    .high_code_o         (out_high_code_o),
    .low_code_o          (out_low_code_o)
  );

  // high capture never ends calibration in the same step
  a_cap_keeps_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_high_captured_o |-> out_calibrating_o)
    else $error("high capture with calibration off");

  // saving the codes ends calibration
  a_saved_ends_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_calibration_saved_o |-> !out_calibrating_o)
    else $error("calibration still active after save");

  // ignored pulses never raise completion flags
  a_flags_need_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_pulse_in_range_o
      |-> !out_high_captured_o && !out_calibration_saved_o)
    else $error("completion flag on ignored pulse");

endmodule
`default_nettype wire

@@ bench/servo_pulse_throttle_decoder_test.sv @@
`timescale 1ns / 1ps
`default_nettype none
module servo_pulse_throttle_decoder_test;
  import spt_pkg::*;

  // Expected result of one request
  typedef struct packed {
    logic [ThrW-1:0]  throttle;
    logic [ThrW-1:0]  raw_value;
    logic             in_range;
    logic             calibrating;
    logic             high_captured;
    logic             cal_saved;
    logic [CodeW-1:0] high_code;
    logic [CodeW-1:0] low_code;
  } thr_result_t;

  int unsigned n_errors = 0;

  // One line per mismatch, counted.
  task automatic report_mismatch(input string what, input int got, input int want);
    n_errors++;
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
  endtask

  // Throttle decoder model plus the queue of results it predicts.
  class throttle_scoreboard;
    bit bidir;
    int neutral, max_step, low_init, high_init;
    bit cal_start;
    bit cal_on, hi_done;
    int hi_cnt, lo_cnt;
    int last_hi, low_end, high_end;
    int held, smooth;
    thr_result_t pending[$];

    function new();
      bidir = RstBidir; neutral = RstNeutral; max_step = RstMaxStep;
      low_init = RstLowInit; high_init = RstHighInit; cal_start = RstCalStart;
      cal_on = cal_start; hi_done = 0; hi_cnt = 0; lo_cnt = 0; last_hi = 0;
      low_end = low_init; high_end = high_init; held = 0; smooth = 0;
    endfunction

    // sign-extend a 16 bit value
    function int s16(int v);
      v = v & 16'hFFFF;
      return (v & 16'h8000) ? v - 65536 : v;
    endfunction

    function int map_lin(int x, int lo, int hi, int olo, int ohi);
      if (hi <= lo) return olo;
      if (x < lo) x = lo;
      if (x > hi) x = hi;
      return (x - lo) * (ohi - olo) / (hi - lo) + olo;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, int val);
      case (idx)
        RegBidir:    bidir = val[0];
        RegNeutral:  neutral = val & 12'hFFF;
        RegMaxStep:  max_step = val & 11'h7FF;
        RegLowInit: begin
          low_init = val & 11'h7FF; low_end = low_init;
        end
        RegHighInit: begin
          high_init = val & 12'hFFF; high_end = high_init;
        end
        RegCalStart: begin
          cal_start = val[0]; cal_on = cal_start;
          hi_done = 0; hi_cnt = 0; lo_cnt = 0; last_hi = 0;
        end
        default: ;
      endcase
    endfunction

    function void note_request(int w);
      thr_result_t r;
      bit ok, cap, saved;
      int h, d, raw, sm;
      ok = (w > 800) && (w < 2200);
      cap = 0; saved = 0;
      if (ok) begin
        if (cal_on) begin
          if (!hi_done) begin
            h = s16(high_end);
            if (hi_cnt == 0) last_hi = w;
            hi_cnt = (hi_cnt + 1) & 8'hFF;
            d = s16(last_hi) - h;
            if (d < 0) d = -d;
            if (d > 50) cal_on = 0;
            else begin
              h = (7 * h + w) >>> 3;
              if (hi_cnt > 50) begin
                h -= 25; hi_done = 1; cap = 1;
              end
              high_end = h & 16'hFFFF;
            end
            last_hi = high_end;
          end
          if (hi_done) begin
            if (w < 1250) begin
              lo_cnt = (lo_cnt + 1) & 8'hFF;
              low_end = ((7 * s16(low_end) + w) >>> 3) & 16'hFFFF;
            end
            if (lo_cnt > 75) begin
              low_end = (s16(low_end) + 25) & 16'hFFFF;
              cal_on = 0; lo_cnt = 0; saved = 1;
            end
          end
        end else begin
          if (bidir) begin
            if (w <= neutral) raw = map_lin(w, s16(low_end), neutral, 0, 1000);
            else raw = map_lin(w, neutral + 1, s16(high_end), 1001, 2000);
          end else begin
            raw = map_lin(w, s16(low_end), s16(high_end), 47, 2047);
            if (raw <= 48) raw = 0;
          end
          held = raw & 11'h7FF;
        end
      end
      sm = smooth;
      if (held - sm > max_step) sm += max_step;
      else if (sm - held > max_step) sm -= max_step;
      else sm = held;
      smooth = sm & 11'h7FF;
      r.throttle = smooth[ThrW-1:0]; r.raw_value = held[ThrW-1:0]; r.in_range = ok;
      r.calibrating = cal_on; r.high_captured = cap; r.cal_saved = saved;
      r.high_code = CodeW'((s16(high_end) - 1750) / 2);
      r.low_code = CodeW'((s16(low_end) - 750) / 2);
      pending.push_back(r);
    endfunction

    task check_result(thr_result_t got);
      thr_result_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
        return;
      end
      e = pending.pop_front();
      if (got.throttle != e.throttle) report_mismatch("throttle", got.throttle, e.throttle);
      if (got.raw_value != e.raw_value) report_mismatch("raw_value", got.raw_value, e.raw_value);
      if (got.in_range != e.in_range) report_mismatch("pulse_in_range", got.in_range, e.in_range);
      if (got.calibrating != e.calibrating)
        report_mismatch("calibrating", got.calibrating, e.calibrating);
      if (got.high_captured != e.high_captured)
        report_mismatch("high_captured", got.high_captured, e.high_captured);
      if (got.cal_saved != e.cal_saved)
        report_mismatch("calibration_saved", got.cal_saved, e.cal_saved);
      if (got.high_code != e.high_code) report_mismatch("high_code", got.high_code, e.high_code);
      if (got.low_code != e.low_code) report_mismatch("low_code", got.low_code, e.low_code);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [PwW-1:0] in_pulse_width_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [ThrW-1:0] out_throttle_o, out_raw_value_o;
  logic out_pulse_in_range_o, out_calibrating_o, out_high_captured_o;
  logic out_calibration_saved_o;
  logic [CodeW-1:0] out_high_code_o, out_low_code_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  servo_pulse_throttle_decoder DUT (.*);

  throttle_scoreboard scb = new();
  bit quiet = 0;          // no idling near the end of the run
  int unsigned n_results = 0, n_cal_done = 0, idle_cycles = 0;
  localparam int unsigned WatchdogLimit = 20000;

  // Result side: sample at the rising edge, random stall bursts.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      thr_result_t g;
      g = {out_throttle_o, out_raw_value_o, out_pulse_in_range_o, out_calibrating_o,
           out_high_captured_o, out_calibration_saved_o, out_high_code_o, out_low_code_o};
      scb.check_result(g);
      n_results++;
      if (out_calibration_saved_o) n_cal_done++;
    end
  end

  initial begin : stall_gen
    int n;
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 14);
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog: cycles with no request, result or register write accepted.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else if (idle_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // One request; valid stays up between back-to-back requests.
  task automatic send_pulse(input int w);
    int n;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 14);
      in_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_pulse_width_i <= w[PwW-1:0];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    scb.note_request(w);
    @(negedge clk_i);
  endtask

  // Wait for every expected result, then let the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (scb.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[CfgDataW-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    scb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Random width: mostly in range, some out of range noise.
  function automatic int rand_width();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 65535);
      1: return $urandom_range(700, 900);
      2: return $urandom_range(2100, 2300);
      default: return $urandom_range(801, 2199);
    endcase
  endfunction

  // Calibration run: high endpoint pulses near high_end, then lows; with drift one high pulse lies far below.
  task automatic run_calibration(input bit drift);
    int hi;
    write_reg(RegCalStart, 1);
    hi = scb.high_end;
    for (int k = 0; k < 52; k++) begin
      if (drift && k == 10) send_pulse(hi - 120);
      else if ($urandom_range(0, 15) == 0) send_pulse(rand_width());
      else send_pulse(hi + $urandom_range(0, 40) - 20);
    end
    for (int k = 0; k < 80; k++) begin
      if ($urandom_range(0, 7) == 0) send_pulse($urandom_range(1250, 2199));
      else send_pulse($urandom_range(801, 1249));
    end
    drain();
  endtask

  initial begin : main
    int dir[$];
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, range borders, unidirectional floor.
    dir = '{0, 65535, 800, 801, 2199, 2200, 1000, 1001, 1500, 2000,
            32768, 1024, 2047, 16'h5555, 16'hAAAA, 900, 1100};
    foreach (dir[i]) send_pulse(dir[i]);
    drain();
    // Bidirectional around neutral, neutral exact and neutral+1.
    write_reg(RegBidir, 1);
    write_reg(RegMaxStep, 2047);
    foreach (dir[i]) send_pulse(dir[i]);
    send_pulse(1500); send_pulse(1501);
    drain();
    // Degenerate map ranges: neutral at the low or high end.
    write_reg(RegNeutral, 800);
    write_reg(RegLowInit, 1260);
    send_pulse(1000); send_pulse(1200);
    drain();
    write_reg(RegNeutral, 2200);
    write_reg(RegHighInit, 1750);
    send_pulse(2100); send_pulse(1300);
    drain();
    write_reg(RegBidir, 0);
    send_pulse(1500);
    drain();
    // Out-of-range register bits are masked off.
    write_reg(RegMaxStep, 12'hFFF);
    write_reg(RegLowInit, 12'hFFF);
    send_pulse(1500); send_pulse(900);
    drain();

    // Random phases through varied settings and calibrations.
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(RegBidir, $urandom_range(0, 1));
      write_reg(RegNeutral, (ph == 0) ? 800 : (ph == 1) ? 2200 : $urandom_range(800, 2200));
      write_reg(RegMaxStep, (ph == 2) ? 0 : (ph == 3) ? 2047 : $urandom_range(0, 400));
      write_reg(RegLowInit, (ph == 4) ? 750 : (ph == 5) ? 1260 : $urandom_range(750, 1260));
      write_reg(RegHighInit, (ph == 4) ? 1750 : (ph == 5) ? 2260 : $urandom_range(1750, 2260));
      write_reg(RegCalStart, 0);
      if (ph % 3 != 2) run_calibration(ph % 4 == 3);
      if (ph == 6) quiet = 0;
      for (int k = 0; k < 60; k++) send_pulse(rand_width());
      drain();
    end
    // Last part: no idling on either side.
    quiet = 1;
    for (int k = 0; k < 200; k++) send_pulse(rand_width());
    drain();

    $display("Covered %0d results, %0d completed calibrations, uni/bidirectional maps",
             n_results, n_cal_done);
    $display("with register extremes, range borders and random stalls.");
    if (n_errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire
